// File: design/dmr_pkg.sv
package dmr_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIAL,
		ST_CLASSIFY,
		ST_SPLIT,
		ST_BASE,
		ST_REDUCE,
		ST_POW,
		ST_POW_SQ,
		ST_XCHK,
		ST_SQLOOP,
		ST_SQCHK,
		ST_NEXT,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_ACC,
		OP_BASE,
		OP_SQR
	} op_t;

	// Status returned by the modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

	localparam int NUM_TRIAL = 6;
	localparam logic [4:0] TRIAL_DIV [NUM_TRIAL] = '{5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17};

	localparam logic [30:0] SMALL_PRIME_MASK = 31'h208A28AC;
	localparam logic [63:0] SMALL_LIMIT = 64'd31;
	localparam logic [63:0] TRIAL_LIMIT = 64'd323;

	localparam logic [63:0] SET_LIMIT [4] = '{
		64'd5329, 64'd9080191, 64'd4759123141, 64'd1122004669633
	};

	localparam logic [2:0] WIT_COUNT [5] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd7};

	localparam logic [63:0] WIT_TABLE [5][7] = '{
		'{64'd377687, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0},
		'{64'd31, 64'd73, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0},
		'{64'd2, 64'd7, 64'd61, 64'd0, 64'd0, 64'd0, 64'd0},
		'{64'd2, 64'd13, 64'd23, 64'd1662803, 64'd0, 64'd0, 64'd0},
		'{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
			64'd1795265022}
	};

endpackage

// File: design/dmr_modmul.sv
module dmr_modmul import dmr_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] op_a,
	input  logic [W-1:0] op_b,
	input  logic [W-1:0] modulus,
	output mm_status_t   status,
	output logic [W-1:0] prod
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [W:0]   dbl;
	logic [W:0]   dbl_red;
	logic [W:0]   sum;
	logic [W-1:0] acc_next;

	// One bit of op_b per cycle, most significant first: double, then add.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
		sum = {1'b0, dbl_red[W-1:0]} + {1'b0, a_q};
		if (sum >= {1'b0, modulus}) begin
			sum = sum - {1'b0, modulus};
		end
		acc_next = b_q[W-1] ? sum[W-1:0] : dbl_red[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= op_a;
			b_q <= op_b;
		end else if (run_q) begin
			acc_q <= acc_next;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign status.busy = run_q;
	assign status.done = done_q;
	assign prod = acc_q;

`ifndef SYNTH
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q)) else $error("done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q) else $error("start while busy");
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |=> acc_q < modulus) else $error("accumulator not reduced");
`endif

endmodule

// File: design/deterministic_miller_rabin_prime_test.sv
// Deterministic Miller-Rabin primality test, one candidate per beat.
// Candidates settled by the small-prime mask or trial division finish after the trial-division pass;
// the others go on to Miller-Rabin rounds with up to seven bases, each run on the bit-serial
// modular multiplier at one bit per cycle.
// Throughput: one candidate at a time; the next beat is taken once the result is registered.
// Reset: arst_n asynchronously clears the controller and the result valid flag.
module deterministic_miller_rabin_prime_test import dmr_pkg::*; #(
	parameter int NUMBER_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cand_valid,
	output logic                    cand_stall,
	input  logic [NUMBER_WIDTH-1:0] candidate,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic                    is_prime
);

	localparam int W = NUMBER_WIDTH;
	localparam int CW = $clog2(W);

	state_t state_q, state_next;
	op_t    op_q, op_next;

	logic [W-1:0]  n_q;
	logic [W-1:0]  tsh_q;
	logic [CW-1:0] cnt_q;
	logic [4:0]    rem_q [NUM_TRIAL];
	logic [W-1:0]  d_q;
	logic [W-1:0]  e_q;
	logic [CW-1:0] s_q;
	logic [CW-1:0] r_q;
	logic [2:0]    set_q;
	logic [2:0]    bidx_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  base_q;
	logic          verdict_q;
	logic          res_valid_q;
	logic          is_prime_q;

	logic [63:0]  n64;
	logic [W-1:0] nm1;
	logic         accept;
	logic         out_free;
	logic         divisible;
	logic         small_bit;
	logic [2:0]   set_sel;
	logic         last_base;
	logic [W-1:0] witness;
	logic         mm_start;
	logic [W-1:0] mm_a;
	logic [W-1:0] mm_b;
	logic [W-1:0] mm_prod;
	mm_status_t   mm_status;
	logic [4:0]   rem_next [NUM_TRIAL];

	assign n64 = 64'(n_q);
	assign nm1 = n_q - 1'b1;
	assign accept = cand_valid && !cand_stall;
	assign out_free = !res_valid_q || !res_stall;
	assign small_bit = SMALL_PRIME_MASK[n_q[4:0]];
	assign last_base = (bidx_q == WIT_COUNT[set_q] - 3'd1);
	assign witness = WIT_TABLE[set_q][bidx_q][W-1:0];

	// Residues of the candidate by the small odd primes, built one bit per cycle.
	always_comb begin
		logic [5:0] t;
		t = '0;
		for (int k = 0; k < NUM_TRIAL; k++) begin
			t = {rem_q[k], tsh_q[W-1]};
			rem_next[k] = (t >= {1'b0, TRIAL_DIV[k]}) ? 5'(t - {1'b0, TRIAL_DIV[k]}) : t[4:0];
		end
	end

	always_comb begin
		divisible = !n_q[0];
		for (int k = 0; k < NUM_TRIAL; k++) begin
			if (rem_q[k] == 5'd0) begin
				divisible = 1'b1;
			end
		end
	end

	// Base set: first cutoff above the candidate, else the full set.
	always_comb begin
		priority if (n64 < SET_LIMIT[0]) set_sel = 3'd0;
		else if (n64 < SET_LIMIT[1]) set_sel = 3'd1;
		else if (n64 < SET_LIMIT[2]) set_sel = 3'd2;
		else if (n64 < SET_LIMIT[3]) set_sel = 3'd3;
		else set_sel = 3'd4;
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_next = ST_TRIAL;
			ST_TRIAL: if (cnt_q == '0) state_next = ST_CLASSIFY;
			ST_CLASSIFY: begin
				if (n64 < SMALL_LIMIT || divisible || n64 < TRIAL_LIMIT) begin
					state_next = ST_DONE;
				end else begin
					state_next = ST_SPLIT;
				end
			end
			ST_SPLIT: if (d_q[0]) state_next = ST_BASE;
			ST_BASE: state_next = ST_REDUCE;
			ST_REDUCE: state_next = ST_WAIT;
			ST_POW: state_next = (e_q == '0) ? ST_XCHK : ST_WAIT;
			ST_POW_SQ: state_next = ST_WAIT;
			ST_XCHK: begin
				state_next = (acc_q == W'(1) || acc_q == nm1) ? ST_NEXT : ST_SQLOOP;
			end
			ST_SQLOOP: state_next = (r_q < s_q) ? ST_WAIT : ST_DONE;
			ST_SQCHK: begin
				priority if (acc_q == W'(1)) state_next = ST_DONE;
				else if (acc_q == nm1) state_next = ST_NEXT;
				else state_next = ST_SQLOOP;
			end
			ST_NEXT: state_next = last_base ? ST_DONE : ST_REDUCE;
			ST_WAIT: begin
				if (mm_status.done) begin
					unique case (op_q)
						OP_REDUCE: state_next = (mm_prod == '0) ? ST_NEXT : ST_POW;
						OP_ACC: state_next = ST_POW_SQ;
						OP_BASE: state_next = ST_POW;
						OP_SQR: state_next = ST_SQCHK;
						default: state_next = ST_IDLE;
					endcase
				end
			end
			ST_DONE: if (out_free) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	// Multiplier issue and operand selection.
	always_comb begin
		mm_start = 1'b0;
		op_next = op_q;
		unique case (state_q)
			ST_REDUCE: begin
				mm_start = 1'b1;
				op_next = OP_REDUCE;
			end
			ST_POW: begin
				mm_start = (e_q != '0);
				op_next = e_q[0] ? OP_ACC : OP_BASE;
			end
			ST_POW_SQ: begin
				mm_start = 1'b1;
				op_next = OP_BASE;
			end
			ST_SQLOOP: begin
				mm_start = (r_q < s_q);
				op_next = OP_SQR;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
		unique case (op_next)
			OP_REDUCE: begin
				mm_a = W'(1);
				mm_b = witness;
			end
			OP_ACC: begin
				mm_a = acc_q;
				mm_b = base_q;
			end
			OP_BASE: begin
				mm_a = base_q;
				mm_b = base_q;
			end
			OP_SQR: begin
				mm_a = acc_q;
				mm_b = acc_q;
			end
			default: begin
				mm_a = acc_q;
				mm_b = acc_q;
			end
		endcase
	end

	dmr_modmul #(
		.W(W)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.modulus (n_q),
		.status  (mm_status),
		.prod    (mm_prod)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_REDUCE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			op_q <= op_next;
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q <= candidate;
					tsh_q <= candidate;
					cnt_q <= CW'(W - 1);
					for (int k = 0; k < NUM_TRIAL; k++) begin
						rem_q[k] <= 5'd0;
					end
				end
			end
			ST_TRIAL: begin
				// Shift the candidate out, most significant bit first.
				for (int k = 0; k < NUM_TRIAL; k++) begin
					rem_q[k] <= rem_next[k];
				end
				tsh_q <= {tsh_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_CLASSIFY: begin
				d_q <= nm1;
				s_q <= '0;
				priority if (n64 < SMALL_LIMIT) verdict_q <= small_bit;
				else if (divisible) verdict_q <= 1'b0;
				else verdict_q <= 1'b1;
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[W-1:1]};
					s_q <= s_q + 1'b1;
				end
			end
			ST_BASE: begin
				set_q <= set_sel;
				bidx_q <= '0;
			end
			ST_XCHK: r_q <= CW'(1);
			ST_SQLOOP: if (r_q >= s_q) verdict_q <= 1'b0;
			ST_SQCHK: begin
				if (acc_q == W'(1)) verdict_q <= 1'b0;
				r_q <= r_q + 1'b1;
			end
			ST_NEXT: begin
				if (last_base) verdict_q <= 1'b1;
				bidx_q <= bidx_q + 3'd1;
			end
			ST_WAIT: begin
				if (mm_status.done) begin
					unique case (op_q)
						OP_REDUCE: begin
							base_q <= mm_prod;
							acc_q <= W'(1);
							e_q <= d_q;
						end
						OP_ACC: acc_q <= mm_prod;
						OP_BASE: begin
							base_q <= mm_prod;
							e_q <= {1'b0, e_q[W-1:1]};
						end
						OP_SQR: acc_q <= mm_prod;
						default: acc_q <= mm_prod;
					endcase
				end
			end
			ST_DONE: if (out_free) is_prime_q <= verdict_q;
			default: begin
			end
		endcase
	end

	assign cand_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign is_prime = is_prime_q;

`ifndef SYNTH
	a_accept_starts_trial: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_TRIAL) else $error("accepted beat did not start");
	a_mm_idle_on_issue: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_status.busy) else $error("multiplier issued while busy");
	a_mr_large_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REDUCE |-> n64 >= TRIAL_LIMIT) else $error("small candidate in MR");
	a_x_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_XCHK |-> acc_q < n_q) else $error("power not reduced");
`endif

endmodule
